### hw/rtl/ray_polygon_intersect_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the ray/polygon intersection RTL
// ----------------------------------------------------------------------------
`ifndef RAY_POLYGON_INTERSECT_MACROS_SVH
`define RAY_POLYGON_INTERSECT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define RPI_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define RPI_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/rpi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpi_pkg
// Shared codes, defaults and fixed-point helpers for ray/polygon intersection.
// ----------------------------------------------------------------------------
package rpi_pkg;

	localparam int MAX_VERTICES_DEF = 4;
	localparam int FRAC_BITS_DEF    = 16;

	localparam int COORD_W = 32;
	localparam int DIV_W   = 64;
	localparam int VCNT_W  = 3;
	localparam int THR_W   = 17;

	localparam logic [VCNT_W-1:0] VCNT_RESET = 3'd4;
	localparam logic [THR_W-1:0]  THR_RESET  = 17'd7;

	typedef enum logic [1:0] {
		MODE_VERTEX = 2'd0,
		MODE_NORMAL = 2'd1,
		MODE_CAST   = 2'd2
	} mode_t;

	// register index is paddr[2]
	localparam logic REG_VERTEX_COUNT = 1'b0;
	localparam logic REG_PARALLEL_THR = 1'b1;

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		logic signed [65:0] hi;
		logic signed [65:0] lo;
		hi = 66'sd2147483647;
		lo = -66'sd2147483648;
		if (v > hi) begin
			return 32'sh7fffffff;
		end else if (v < lo) begin
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

	function automatic logic [31:0] mag32(input logic signed [31:0] v);
		logic signed [31:0] n;
		n = -v;
		return v[31] ? 32'(n) : 32'(v);
	endfunction

	function automatic logic [63:0] mag64(input logic signed [63:0] v);
		logic signed [63:0] n;
		n = -v;
		return v[63] ? 64'(n) : 64'(v);
	endfunction

endpackage

### hw/rtl/rpi_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpi_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rpi_ram #(
	parameter int WIDTH = 96,
	parameter int DEPTH = 4,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### hw/rtl/ray_polygon_intersect.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_polygon_intersect
// Ray against a 3..MAX_VERTICES vertex polygon, Q fixed point, even-odd test.
// ----------------------------------------------------------------------------
// Load beats (vertex, plane normal) give no result. A cast beat runs on one
// shared 32x32 multiplier and one shared restoring divider (one quotient bit
// per cycle, 64 bits) under a small sequencer: it takes the beat, forms d.n,
// then the numerator, divides for t, forms the hit point and primes the
// vertex read, then for each polygon edge tests it against the scan line,
// divides when the edge crosses it, and finally loads the output register.
// A ray parallel to the plane goes straight to the output register with no
// hit. The input is not ready while a cast is in flight; one finished
// result may wait in the output register while the next beat is taken.
// ----------------------------------------------------------------------------
`include "ray_polygon_intersect_macros.svh"

module ray_polygon_intersect #(
	parameter int MAX_VERTICES = rpi_pkg::MAX_VERTICES_DEF,
	parameter int FRAC_BITS    = rpi_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// APB configuration port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	// input channel
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         mode,
	input  logic [1:0]         vertex_slot,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic signed [31:0] dir_x,
	input  logic signed [31:0] dir_y,
	input  logic signed [31:0] dir_z,
	// result channel
	output logic               out_valid,
	input  logic               out_ready,
	output logic               hit,
	output logic signed [31:0] hit_x,
	output logic signed [31:0] hit_y,
	output logic signed [31:0] hit_z
);

	localparam int VA = $clog2(MAX_VERTICES);
	localparam int VW = 3 * rpi_pkg::COORD_W;

	typedef enum logic [20:0] {
		S_IDLE     = 21'h000001,
		S_DEN_M    = 21'h000002,
		S_DEN_A    = 21'h000004,
		S_DEN_CHK  = 21'h000008,
		S_NUM_M    = 21'h000010,
		S_NUM_A    = 21'h000020,
		S_NUM_FIN  = 21'h000040,
		S_DIV_T    = 21'h000080,
		S_T_FIN    = 21'h000100,
		S_HIT_M    = 21'h000200,
		S_HIT_A    = 21'h000400,
		S_VRD      = 21'h000800,
		S_VLAT     = 21'h001000,
		S_EDGE_T   = 21'h002000,
		S_EDGE_M   = 21'h004000,
		S_EDGE_DS  = 21'h008000,
		S_EDGE_D   = 21'h010000,
		S_EDGE_C   = 21'h020000,
		S_EDGE_NXT = 21'h040000,
		S_EDGE_RD  = 21'h080000,
		S_OUT      = 21'h100000
	} state_t;

	function automatic logic signed [31:0] pick3(input logic [1:0] k,
		input logic signed [31:0] a0, input logic signed [31:0] a1,
		input logic signed [31:0] a2);
		logic signed [31:0] r;
		case (k)
			2'd0: r = a0;
			2'd1: r = a1;
			default: r = a2;
		endcase
		return r;
	endfunction

	function automatic logic signed [31:0] vcomp(input logic [VW-1:0] w, input logic [1:0] k);
		logic signed [31:0] r;
		case (k)
			2'd0: r = w[31:0];
			2'd1: r = w[63:32];
			default: r = w[95:64];
		endcase
		return r;
	endfunction

	state_t state_q;

	logic [rpi_pkg::VCNT_W-1:0] vcount_q;
	logic [rpi_pkg::THR_W-1:0]  thr_q;

	logic signed [31:0] p_q [3];
	logic signed [31:0] d_q [3];
	logic signed [31:0] n_q [3];
	logic signed [31:0] h_q [3];
	logic signed [31:0] den_q, t_q;
	logic signed [31:0] du_q, dw_q, dz_q, prev_u_q, prev_w_q;
	logic signed [63:0] prod_q;
	logic signed [65:0] acc_q;
	logic [1:0]         k_q;
	logic [VA-1:0]      i_q;
	logic               in_q;

	logic [63:0] dvd_q;
	logic [32:0] rem_q;
	logic [31:0] dvs_q;
	logic [5:0]  cnt_q;
	logic        neg_q;

	logic        out_valid_q, res_hit_q;
	logic signed [31:0] res_x_q, res_y_q, res_z_q;

	// --- configuration port
	logic cfg_wr;
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = (paddr[2] == rpi_pkg::REG_PARALLEL_THR) ?
		{15'd0, thr_q} : {29'd0, vcount_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= rpi_pkg::VCNT_RESET;
			thr_q    <= rpi_pkg::THR_RESET;
		end else if (cfg_wr) begin
			if (paddr[2] == rpi_pkg::REG_VERTEX_COUNT) begin
				vcount_q <= pwdata[rpi_pkg::VCNT_W-1:0];
			end else begin
				thr_q <= pwdata[rpi_pkg::THR_W-1:0];
			end
		end
	end

	// --- vertex store
	logic          in_acc, ram_we;
	logic [VA-1:0] ram_raddr, nlast;
	logic [VW-1:0] ram_rdata;

	assign in_ready = (state_q == S_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign ram_we   = in_acc && (mode == rpi_pkg::MODE_VERTEX) &&
		(32'(vertex_slot) < MAX_VERTICES);

	always_comb begin
		if (vcount_q < 3'd3) begin
			nlast = VA'(2);
		end else if (32'(vcount_q) > MAX_VERTICES) begin
			nlast = VA'(MAX_VERTICES - 1);
		end else begin
			nlast = VA'(vcount_q - 3'd1);
		end
	end

	assign ram_raddr = (state_q == S_VRD) ? nlast : i_q;

	rpi_ram #(
		.WIDTH(VW),
		.DEPTH(MAX_VERTICES)
	) u_vstore (
		.clk  (clk),
		.we   (ram_we),
		.waddr(VA'(vertex_slot)),
		.wdata({pos_z, pos_y, pos_x}),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// --- projection: drop the dominant normal axis, ties to XY
	logic [31:0] ax, ay, az;
	logic [1:0]  ui, wi;
	assign ax = rpi_pkg::mag32(n_q[0]);
	assign ay = rpi_pkg::mag32(n_q[1]);
	assign az = rpi_pkg::mag32(n_q[2]);

	always_comb begin
		if (ax > ay && ax > az) begin
			ui = 2'd1;
			wi = 2'd2;
		end else if (ay > ax && ay > az) begin
			ui = 2'd0;
			wi = 2'd2;
		end else begin
			ui = 2'd0;
			wi = 2'd1;
		end
	end

	logic signed [31:0] pu, pw, cu, cw;
	assign pu = pick3(ui, h_q[0], h_q[1], h_q[2]);
	assign pw = pick3(wi, h_q[0], h_q[1], h_q[2]);
	assign cu = vcomp(ram_rdata, ui);
	assign cw = vcomp(ram_rdata, wi);

	// --- shared multiplier
	logic signed [31:0] mul_a, mul_b, pk, dk, nk;
	assign pk = pick3(k_q, p_q[0], p_q[1], p_q[2]);
	assign dk = pick3(k_q, d_q[0], d_q[1], d_q[2]);
	assign nk = pick3(k_q, n_q[0], n_q[1], n_q[2]);

	always_comb begin
		case (state_q)
			S_DEN_M: begin
				mul_a = dk;
				mul_b = nk;
			end
			S_NUM_M: begin
				mul_a = rpi_pkg::sat32(66'(vcomp(ram_rdata, k_q)) - 66'(pk));
				mul_b = nk;
			end
			S_HIT_M: begin
				mul_a = dk;
				mul_b = t_q;
			end
			default: begin
				mul_a = du_q;
				mul_b = dw_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= 64'(mul_a) * 64'(mul_b);
	end

	// product scaled down, truncating toward zero
	logic signed [63:0] bias, qm;
	assign bias = (64'sd1 <<< FRAC_BITS) - 64'sd1;
	assign qm   = (prod_q[63] ? prod_q + bias : prod_q) >>> FRAC_BITS;

	// --- shared divider step and signed quotient
	logic [32:0]        rem_sh, rem_n;
	logic               q_ge;
	logic signed [65:0] q_ext, sq;
	logic signed [31:0] acc_sat;
	logic signed [63:0] num_sh;

	assign rem_sh  = {rem_q[31:0], dvd_q[63]};
	assign q_ge    = rem_sh >= {1'b0, dvs_q};
	assign rem_n   = q_ge ? rem_sh - {1'b0, dvs_q} : rem_sh;
	assign q_ext   = $signed({2'b00, dvd_q});
	assign sq      = neg_q ? -q_ext : q_ext;
	assign acc_sat = rpi_pkg::sat32(acc_q);
	assign num_sh  = 64'(acc_sat) <<< FRAC_BITS;

	// --- sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			k_q         <= 2'd0;
			i_q         <= '0;
			cnt_q       <= '0;
		end else begin
			// load the output register when free, drop the beat once taken
			if (state_q == S_OUT && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc && mode == rpi_pkg::MODE_CAST) begin
						k_q     <= 2'd0;
						i_q     <= '0;
						state_q <= S_DEN_M;
					end
				end
				S_DEN_M: state_q <= S_DEN_A;
				S_DEN_A: begin
					if (k_q == 2'd2) begin
						k_q     <= 2'd0;
						state_q <= S_DEN_CHK;
					end else begin
						k_q     <= k_q + 2'd1;
						state_q <= S_DEN_M;
					end
				end
				S_DEN_CHK: begin
					if (33'(rpi_pkg::mag32(acc_sat)) <= 33'(thr_q)) begin
						state_q <= S_OUT;
					end else begin
						state_q <= S_NUM_M;
					end
				end
				S_NUM_M: state_q <= S_NUM_A;
				S_NUM_A: begin
					if (k_q == 2'd2) begin
						k_q     <= 2'd0;
						state_q <= S_NUM_FIN;
					end else begin
						k_q     <= k_q + 2'd1;
						state_q <= S_NUM_M;
					end
				end
				S_NUM_FIN: begin
					cnt_q   <= 6'd63;
					state_q <= S_DIV_T;
				end
				S_DIV_T: begin
					cnt_q <= cnt_q - 6'd1;
					if (cnt_q == 6'd0) begin
						state_q <= S_T_FIN;
					end
				end
				S_T_FIN: state_q <= S_HIT_M;
				S_HIT_M: state_q <= S_HIT_A;
				S_HIT_A: begin
					if (k_q == 2'd2) begin
						k_q     <= 2'd0;
						state_q <= S_VRD;
					end else begin
						k_q     <= k_q + 2'd1;
						state_q <= S_HIT_M;
					end
				end
				S_VRD: state_q <= S_VLAT;
				S_VLAT: state_q <= S_EDGE_T;
				S_EDGE_T: begin
					if ((cw > pw) != (prev_w_q > pw)) begin
						state_q <= S_EDGE_M;
					end else begin
						state_q <= S_EDGE_NXT;
					end
				end
				S_EDGE_M: state_q <= S_EDGE_DS;
				S_EDGE_DS: begin
					cnt_q   <= 6'd63;
					state_q <= S_EDGE_D;
				end
				S_EDGE_D: begin
					cnt_q <= cnt_q - 6'd1;
					if (cnt_q == 6'd0) begin
						state_q <= S_EDGE_C;
					end
				end
				S_EDGE_C: state_q <= S_EDGE_NXT;
				S_EDGE_NXT: begin
					if (i_q == nlast) begin
						state_q <= S_OUT;
					end else begin
						i_q     <= i_q + VA'(1);
						state_q <= S_EDGE_RD;
					end
				end
				S_EDGE_RD: state_q <= S_EDGE_T;
				S_OUT: begin
					// hold until the output register is free
					if (!out_valid_q || out_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// --- datapath registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			case (mode)
				rpi_pkg::MODE_NORMAL: begin
					n_q[0] <= pos_x;
					n_q[1] <= pos_y;
					n_q[2] <= pos_z;
				end
				rpi_pkg::MODE_CAST: begin
					p_q[0] <= pos_x;
					p_q[1] <= pos_y;
					p_q[2] <= pos_z;
					d_q[0] <= dir_x;
					d_q[1] <= dir_y;
					d_q[2] <= dir_z;
					acc_q  <= '0;
					in_q   <= 1'b0;
				end
				default: ;
			endcase
		end
		case (state_q)
			S_DEN_A, S_NUM_A: acc_q <= acc_q + 66'(qm);
			S_DEN_CHK: begin
				den_q <= acc_sat;
				acc_q <= '0;
				if (33'(rpi_pkg::mag32(acc_sat)) <= 33'(thr_q)) begin
					h_q[0] <= '0;
					h_q[1] <= '0;
					h_q[2] <= '0;
				end
			end
			S_NUM_FIN: begin
				dvd_q <= rpi_pkg::mag64(num_sh);
				rem_q <= '0;
				dvs_q <= rpi_pkg::mag32(den_q);
				neg_q <= acc_sat[31] ^ den_q[31];
			end
			S_DIV_T, S_EDGE_D: begin
				rem_q <= rem_n;
				dvd_q <= {dvd_q[62:0], q_ge};
			end
			S_T_FIN: t_q <= rpi_pkg::sat32(sq);
			S_HIT_A: begin
				case (k_q)
					2'd0: h_q[0] <= rpi_pkg::sat32(66'(pk) + 66'(qm));
					2'd1: h_q[1] <= rpi_pkg::sat32(66'(pk) + 66'(qm));
					default: h_q[2] <= rpi_pkg::sat32(66'(pk) + 66'(qm));
				endcase
			end
			S_VLAT: begin
				prev_u_q <= cu;
				prev_w_q <= cw;
			end
			S_EDGE_T: begin
				du_q <= rpi_pkg::sat32(66'(prev_u_q) - 66'(cu));
				dw_q <= rpi_pkg::sat32(66'(pw) - 66'(cw));
				dz_q <= rpi_pkg::sat32(66'(prev_w_q) - 66'(cw));
			end
			S_EDGE_DS: begin
				dvd_q <= rpi_pkg::mag64(prod_q);
				rem_q <= '0;
				dvs_q <= rpi_pkg::mag32(dz_q);
				neg_q <= prod_q[63] ^ dz_q[31];
			end
			S_EDGE_C: begin
				if (66'(pu) < sq + 66'(cu)) begin
					in_q <= !in_q;
				end
			end
			S_EDGE_NXT: begin
				prev_u_q <= cu;
				prev_w_q <= cw;
			end
			S_OUT: begin
				if (!out_valid_q || out_ready) begin
					res_hit_q <= in_q;
					res_x_q   <= h_q[0];
					res_y_q   <= h_q[1];
					res_z_q   <= h_q[2];
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign hit       = res_hit_q;
	assign hit_x     = res_x_q;
	assign hit_y     = res_y_q;
	assign hit_z     = res_z_q;

	`RPI_ASSERT_NXT(a_cast_busy, clk, arst_n, in_valid && in_ready && mode == rpi_pkg::MODE_CAST, !in_ready, "cast beat did not make the block busy")
	`RPI_ASSERT_IMP(a_edge_index, clk, arst_n, state_q == S_EDGE_T, i_q <= nlast, "edge index past vertex count")
	`RPI_ASSERT_IMP(a_div_nonzero, clk, arst_n, state_q == S_DIV_T || state_q == S_EDGE_D, dvs_q != '0, "divider running with zero divisor")
	`RPI_ASSERT_NXT(a_out_wait, clk, arst_n, state_q == S_OUT && out_valid && !out_ready, state_q == S_OUT, "result dropped while output register full")

endmodule
